// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of the core.
// Clock and reset are taken from the scope that expands the macro (clk, rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is active.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/core/bwlpf_pkg.sv -----
// Types, constants and coefficient table of the dual Butterworth low-pass core.
// No dependencies; imported by every other source file of the core but assert_macros.svh.
package bwlpf_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CHANNELS_DEF    = 2;
    localparam int IO_FIELDS       = 2;
    localparam int CHAN_BITS       = $clog2(IO_FIELDS);
    localparam int COEF_BITS       = 16;
    localparam int COEF_FRAC       = 14;
    localparam int SECT_SHIFT      = 8;
    localparam int TAP_BITS        = 3;

    typedef logic [CHAN_BITS-1:0]        chan_t;
    typedef logic [TAP_BITS-1:0]         tap_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;

    localparam tap_t TAP_X0    = 3'd0;
    localparam tap_t TAP_X1    = 3'd1;
    localparam tap_t TAP_X2    = 3'd2;
    localparam tap_t TAP_Y1    = 3'd3;
    localparam tap_t TAP_Y2    = 3'd4;
    localparam tap_t TAP_DRAIN = 3'd5;

    // Q2.14; feedback terms are stored negated so every tap accumulates.
    localparam coef_t CB0 = 16'sd218;
    localparam coef_t CB1 = 16'sd436;
    localparam coef_t NA1 = 16'sd26214;
    localparam coef_t NA2 = -16'sd10702;
    localparam coef_t ND1 = 16'sd22548;
    localparam coef_t ND2 = -16'sd7035;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        tap_t    tap;
        logic    sect;
        chan_t   chan;
        acc_op_t acc_op;
        logic    store;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic coef_t tap_coef(input logic sect, input tap_t tap);
        coef_t c;
        case (tap)
            TAP_X0:  c = CB0;
            TAP_X1:  c = CB1;
            TAP_X2:  c = CB0;
            TAP_Y1:  c = sect ? ND1 : NA1;
            TAP_Y2:  c = sect ? ND2 : NA2;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/bwlpf_sample_if.sv -----
// Request channel carrying one roll and one pitch sample.
// Depends on bwlpf_pkg for the default sample width.
interface bwlpf_sample_if import bwlpf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] roll_sample;
    logic signed [SAMPLE_BITS-1:0] pitch_sample;

    modport source (output valid, output roll_sample, output pitch_sample, input ready);
    modport sink   (input valid, input roll_sample, input pitch_sample, output ready);
endinterface

// ----- rtl/core/bwlpf_filtered_if.sv -----
// Result channel carrying the filtered roll and pitch values.
// Depends on bwlpf_pkg for the default sample width.
interface bwlpf_filtered_if import bwlpf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] roll_filtered;
    logic signed [SAMPLE_BITS-1:0] pitch_filtered;

    modport source (output valid, output roll_filtered, output pitch_filtered, input ready);
    modport sink   (input valid, input roll_filtered, input pitch_filtered, output ready);
endinterface

// ----- rtl/core/bwlpf_ctrl.sv -----
// Sequencer of the low-pass core: walks channels, sections and taps.
// Depends on bwlpf_pkg; drives the datapath through cmd_t.
module bwlpf_ctrl import bwlpf_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int    ACT       = (CHANNELS < IO_FIELDS) ? CHANNELS : IO_FIELDS;
    localparam chan_t CHAN_LAST = chan_t'(ACT - 1);

    state_t state_reg, state_next;
    tap_t   tap_reg,   tap_next;
    logic   sect_reg,  sect_next;
    chan_t  chan_reg,  chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= TAP_X0;
            sect_reg  <= 1'b0;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            sect_reg  <= sect_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        sect_next    = sect_reg;
        chan_next    = chan_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.tap      = tap_reg;
        cmd.sect     = sect_reg;
        cmd.chan     = chan_reg;
        cmd.acc_op   = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    tap_next    = TAP_X0;
                    sect_next   = 1'b0;
                    chan_next   = '0;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mul_en = (tap_reg != TAP_DRAIN);
                if (tap_reg == TAP_X0)
                    cmd.acc_op = ACC_HOLD;
                else if (tap_reg == TAP_X1)
                    cmd.acc_op = ACC_LOAD;
                else
                    cmd.acc_op = ACC_ADD;
                if (tap_reg == TAP_DRAIN)
                    state_next = ST_ROUND;
                else
                    tap_next = tap_reg + tap_t'(1);
            end
            ST_ROUND:
            begin
                cmd.store = 1'b1;
                tap_next  = TAP_X0;
                if (!sect_reg)
                begin
                    sect_next  = 1'b1;
                    state_next = ST_MAC;
                end
                else if (chan_reg == CHAN_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    chan_next  = chan_reg + chan_t'(1);
                    sect_next  = 1'b0;
                    state_next = ST_MAC;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/bwlpf_dp.sv -----
// Datapath of the low-pass core: filter histories, shared multiplier,
// accumulator, rounding and saturation, output register. Depends on bwlpf_pkg.
module bwlpf_dp import bwlpf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CHANNELS    = CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output status_t                       status,
    input  logic signed [SAMPLE_BITS-1:0] in_roll,
    input  logic signed [SAMPLE_BITS-1:0] in_pitch,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_roll,
    output logic signed [SAMPLE_BITS-1:0] out_pitch
);

    localparam int ACT  = (CHANNELS < IO_FIELDS) ? CHANNELS : IO_FIELDS;
    localparam int SECT = SAMPLE_BITS + SECT_SHIFT;
    localparam int PROD = SECT + COEF_BITS;
    localparam int ACC  = PROD + 3;

    localparam logic signed [ACC-1:0]  ACC_RND = ACC'(1 << (COEF_FRAC - 1));
    localparam logic signed [ACC-1:0]  SECT_HI = {{(ACC - SECT + 1){1'b0}}, {(SECT - 1){1'b1}}};
    localparam logic signed [ACC-1:0]  SECT_LO = ~SECT_HI;
    localparam logic signed [SECT:0]   OUT_RND = (SECT + 1)'(1 << (SECT_SHIFT - 1));
    localparam logic signed [SECT:0]   OUT_HI  =
        {{(SECT - SAMPLE_BITS + 2){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SECT:0]   OUT_LO  = ~OUT_HI;

    logic signed [SAMPLE_BITS-1:0] in_field   [IO_FIELDS];
    logic signed [SAMPLE_BITS-1:0] sample_reg [ACT];
    logic signed [SAMPLE_BITS-1:0] xh0_reg    [ACT];
    logic signed [SAMPLE_BITS-1:0] xh1_reg    [ACT];
    logic signed [SECT-1:0]        y1h0_reg   [ACT];
    logic signed [SECT-1:0]        y1h1_reg   [ACT];
    logic signed [SECT-1:0]        y2h0_reg   [ACT];
    logic signed [SECT-1:0]        y2h1_reg   [ACT];

    logic signed [SAMPLE_BITS-1:0] cur_x, cur_xh0, cur_xh1;
    logic signed [SECT-1:0]        cur_y1h0, cur_y1h1, cur_y2h0, cur_y2h1;
    logic signed [SECT-1:0]        operand;
    coef_t                         coef;
    logic signed [PROD-1:0]        mul_w;
    logic signed [PROD-1:0]        prod_reg;
    logic signed [ACC-1:0]         acc_reg, acc_next;
    logic signed [ACC-1:0]         rnd_sum, rnd_sh;
    logic signed [SECT-1:0]        sect_res;
    logic signed [SECT-1:0]        sec0_reg;

    logic signed [SECT:0]          out_sum [ACT];
    logic signed [SECT:0]          out_sh  [ACT];
    logic signed [SAMPLE_BITS-1:0] out_val [IO_FIELDS];

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_roll_reg;
    logic signed [SAMPLE_BITS-1:0] out_pitch_reg;

    assign in_field[0] = in_roll;
    assign in_field[1] = in_pitch;

    always_comb
    begin
        cur_x    = sample_reg[0];
        cur_xh0  = xh0_reg[0];
        cur_xh1  = xh1_reg[0];
        cur_y1h0 = y1h0_reg[0];
        cur_y1h1 = y1h1_reg[0];
        cur_y2h0 = y2h0_reg[0];
        cur_y2h1 = y2h1_reg[0];
        for (int c = 1; c < ACT; c++)
        begin
            if (cmd.chan == chan_t'(c))
            begin
                cur_x    = sample_reg[c];
                cur_xh0  = xh0_reg[c];
                cur_xh1  = xh1_reg[c];
                cur_y1h0 = y1h0_reg[c];
                cur_y1h1 = y1h1_reg[c];
                cur_y2h0 = y2h0_reg[c];
                cur_y2h1 = y2h1_reg[c];
            end
        end
    end

    always_comb
    begin
        case (cmd.tap)
            TAP_X0:  operand = cmd.sect ? sec0_reg : {cur_x, {SECT_SHIFT{1'b0}}};
            TAP_X1:  operand = cmd.sect ? cur_y1h0 : {cur_xh0, {SECT_SHIFT{1'b0}}};
            TAP_X2:  operand = cmd.sect ? cur_y1h1 : {cur_xh1, {SECT_SHIFT{1'b0}}};
            TAP_Y1:  operand = cmd.sect ? cur_y2h0 : cur_y1h0;
            TAP_Y2:  operand = cmd.sect ? cur_y2h1 : cur_y1h1;
            default: operand = '0;
        endcase
    end

    assign coef  = tap_coef(cmd.sect, cmd.tap);
    assign mul_w = PROD'(operand) * PROD'(coef);

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = ACC'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + ACC'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    // Round half up, floor shift, clamp to the section width.
    assign rnd_sum = acc_reg + ACC_RND;
    assign rnd_sh  = rnd_sum >>> COEF_FRAC;

    always_comb
    begin
        if (rnd_sh > SECT_HI)
            sect_res = SECT_HI[SECT-1:0];
        else if (rnd_sh < SECT_LO)
            sect_res = SECT_LO[SECT-1:0];
        else
            sect_res = rnd_sh[SECT-1:0];
    end

    for (genvar c = 0; c < ACT; c++)
    begin : g_out
        assign out_sum[c] = (SECT + 1)'(y2h0_reg[c]) + OUT_RND;
        assign out_sh[c]  = out_sum[c] >>> SECT_SHIFT;
    end

    always_comb
    begin
        for (int c = 0; c < IO_FIELDS; c++)
            out_val[c] = '0;
        for (int c = 0; c < ACT; c++)
        begin
            if (out_sh[c] > OUT_HI)
                out_val[c] = OUT_HI[SAMPLE_BITS-1:0];
            else if (out_sh[c] < OUT_LO)
                out_val[c] = OUT_LO[SAMPLE_BITS-1:0];
            else
                out_val[c] = out_sh[c][SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            for (int c = 0; c < ACT; c++)
                sample_reg[c] <= in_field[c];
        end
        if (cmd.mul_en)
            prod_reg <= mul_w;
        acc_reg <= acc_next;
        if (cmd.store && !cmd.sect)
            sec0_reg <= sect_res;
        if (cmd.out_load)
        begin
            out_roll_reg  <= out_val[0];
            out_pitch_reg <= out_val[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < ACT; c++)
            begin
                xh0_reg[c]  <= '0;
                xh1_reg[c]  <= '0;
                y1h0_reg[c] <= '0;
                y1h1_reg[c] <= '0;
                y2h0_reg[c] <= '0;
                y2h1_reg[c] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // advance the channel's histories once its second section is done
            if (cmd.store && cmd.sect)
            begin
                for (int c = 0; c < ACT; c++)
                begin
                    if (cmd.chan == chan_t'(c))
                    begin
                        xh1_reg[c]  <= xh0_reg[c];
                        xh0_reg[c]  <= sample_reg[c];
                        y1h1_reg[c] <= y1h0_reg[c];
                        y1h0_reg[c] <= sec0_reg;
                        y2h1_reg[c] <= y2h0_reg[c];
                        y2h0_reg[c] <= sect_res;
                    end
                end
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_roll        = out_roll_reg;
    assign out_pitch       = out_pitch_reg;

endmodule

// ----- rtl/core/butterworth_lowpass_4th_dual.sv -----
// Dual fourth-order Butterworth low-pass (20 Hz at 500 Hz) for roll and pitch.
// Depends on bwlpf_pkg, bwlpf_sample_if, bwlpf_filtered_if, bwlpf_ctrl, bwlpf_dp.
//
// Each request carries one roll and one pitch sample (Q2.13) and yields one result
// with both filtered values, saturated to the sample width. Every channel runs two
// direct-form-I biquads in Q2.21 through a single shared multiply-accumulate unit:
// a section steps through five multiply taps, a drain step and a rounding step, and a
// request walks both sections of each active channel in turn before its result is loaded.
// The result sits in an output register; the next request is taken while it waits,
// and the block stalls only when a new result is ready before the old one is taken.
// Filter histories are zero after reset and no clearing pass is needed.
module butterworth_lowpass_4th_dual import bwlpf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CHANNELS    = CHANNELS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    bwlpf_sample_if.sink     samples,
    bwlpf_filtered_if.source filtered
);

    cmd_t    cmd;
    status_t status;

    bwlpf_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bwlpf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CHANNELS    (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_roll   (samples.roll_sample),
        .in_pitch  (samples.pitch_sample),
        .out_valid (filtered.valid),
        .out_ready (filtered.ready),
        .out_roll  (filtered.roll_filtered),
        .out_pitch (filtered.pitch_filtered)
    );

endmodule

// ----- rtl/core/bwlpf_checker.sv -----
// Port-level checks of the dual low-pass core, bound to its top level.
// Depends on bwlpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bwlpf_checker import bwlpf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] roll_filtered,
    input logic signed [SAMPLE_BITS-1:0] pitch_filtered
);

    `ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !out_valid, "result valid after reset")

    `ASSERT_CLK(a_busy_after_request, in_valid && in_ready |=> !in_ready, "request taken while busy")

    `ASSERT_CLK(a_result_after_work, $rose(out_valid) |-> !$past(in_ready), "result without work")

    `ASSERT_CLK(a_result_held, out_valid && !out_ready |=> out_valid, "result dropped")

    `ASSERT_CLK(a_result_stable, out_valid && !out_ready |=> $stable(roll_filtered) && $stable(pitch_filtered), "result changed while stalled")

endmodule

bind butterworth_lowpass_4th_dual bwlpf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bwlpf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (samples.valid),
    .in_ready       (samples.ready),
    .out_valid      (filtered.valid),
    .out_ready      (filtered.ready),
    .roll_filtered  (filtered.roll_filtered),
    .pitch_filtered (filtered.pitch_filtered)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for butterworth_lowpass_4th_dual: a queued request driver and
// a result monitor with a bit-exact fixed-point filter predictor, under random idling.
// Depends on bwlpf_pkg, bwlpf_sample_if and bwlpf_filtered_if from the core.
module tb_top;

    localparam int     SW         = bwlpf_pkg::SAMPLE_BITS_DEF;
    localparam int     SECT_W     = SW + 8;
    localparam int     COEF_SHIFT = 14;
    localparam longint ROUND_HALF = 64'sd8192;
    localparam longint B_OUTER    = 64'sd218;
    localparam longint B_MID      = 64'sd436;
    localparam longint S1_A1      = -64'sd26214;
    localparam longint S1_A2      = 64'sd10702;
    localparam longint S2_A1      = -64'sd22548;
    localparam longint S2_A2      = 64'sd7035;
    localparam int     RANDOM_REQUESTS = 1430;
    localparam int     IDLE_LIMIT      = 2000;
    localparam int     DRAIN_CYCLES    = 64;

    typedef logic signed [SW-1:0]     sample_t;
    typedef logic signed [SECT_W-1:0] sect_t;

    typedef struct packed {
        sample_t roll;
        sample_t pitch;
    } attitude_t;

    logic clk;
    logic rst_n = 1'b0;

    bwlpf_sample_if   #(.SAMPLE_BITS(SW)) smp_if ();
    bwlpf_filtered_if #(.SAMPLE_BITS(SW)) flt_if ();

    butterworth_lowpass_4th_dual #(
        .SAMPLE_BITS (SW),
        .CHANNELS    (2)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (smp_if),
        .filtered (flt_if)
    );

    attitude_t pending_samples [$];
    attitude_t expected_filtered [$];

    sample_t in_hist [2][2];
    sect_t   sect1_hist [2][2];
    sect_t   sect2_hist [2][2];

    int  error_count;
    int  src_gap;
    int  snk_stall;
    bit  src_steady;
    bit  snk_steady;
    int  idle_cycles;

    function automatic longint clamp_to(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic sect_t run_section(longint x0, longint x1, longint x2,
                                          longint y1, longint y2, longint a1, longint a2);
        longint acc;
        acc = B_OUTER * x0 + B_MID * x1 + B_OUTER * x2 - a1 * y1 - a2 * y2;
        acc = (acc + ROUND_HALF) >>> COEF_SHIFT;
        return sect_t'(clamp_to(acc, SECT_W));
    endfunction

    function automatic sample_t filter_channel(int ch, sample_t x);
        sect_t  y;
        sect_t  z;
        longint o;
        y = run_section(longint'(x) * 256, longint'(in_hist[ch][0]) * 256,
                        longint'(in_hist[ch][1]) * 256,
                        sect1_hist[ch][0], sect1_hist[ch][1], S1_A1, S1_A2);
        z = run_section(y, sect1_hist[ch][0], sect1_hist[ch][1],
                        sect2_hist[ch][0], sect2_hist[ch][1], S2_A1, S2_A2);
        in_hist[ch][1]    = in_hist[ch][0];
        in_hist[ch][0]    = x;
        sect1_hist[ch][1] = sect1_hist[ch][0];
        sect1_hist[ch][0] = y;
        sect2_hist[ch][1] = sect2_hist[ch][0];
        sect2_hist[ch][0] = z;
        o = clamp_to((longint'(z) + 128) >>> 8, SW);
        return sample_t'(o);
    endfunction

    function automatic void predict_filtered(sample_t roll, sample_t pitch);
        attitude_t e;
        e.roll  = filter_channel(0, roll);
        e.pitch = filter_channel(1, pitch);
        expected_filtered.push_back(e);
    endfunction

    function automatic void check_filtered(sample_t roll, sample_t pitch);
        attitude_t e;
        if (expected_filtered.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: unexpected result roll=%0d pitch=%0d", $realtime, roll, pitch);
            return;
        end
        e = expected_filtered.pop_front();
        if (e.roll !== roll || e.pitch !== pitch) begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: mismatch roll exp=%0d act=%0d, pitch exp=%0d act=%0d",
                         $realtime, e.roll, roll, e.pitch, pitch);
        end
    endfunction

    function automatic int draw_wait(bit steady);
        return steady ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic sample_t random_sample();
        return sample_t'($urandom());
    endfunction

    function automatic int clamp_level(int v);
        return int'(clamp_to(longint'(v), SW));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        smp_if.valid        = 1'b0;
        smp_if.roll_sample  = '0;
        smp_if.pitch_sample = '0;
        flt_if.ready        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        attitude_t nxt;
        if (!rst_n)
        begin
            smp_if.valid        <= 1'b0;
            smp_if.roll_sample  <= '0;
            smp_if.pitch_sample <= '0;
            src_gap             <= 0;
            src_steady          <= 1'b0;
        end
        else
        begin
            if (smp_if.valid && smp_if.ready)
                predict_filtered(smp_if.roll_sample, smp_if.pitch_sample);
            if (smp_if.valid && !smp_if.ready)
            begin
                // hold the request until taken
            end
            else if (src_gap != 0)
            begin
                smp_if.valid <= 1'b0;
                src_gap      <= src_gap - 1;
            end
            else if (pending_samples.size() != 0)
            begin
                nxt = pending_samples.pop_front();
                smp_if.roll_sample  <= nxt.roll;
                smp_if.pitch_sample <= nxt.pitch;
                smp_if.valid        <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    src_steady <= !src_steady;
                src_gap <= draw_wait(src_steady);
            end
            else
                smp_if.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int w;
        if (!rst_n)
        begin
            flt_if.ready <= 1'b0;
            snk_stall    <= 0;
            snk_steady   <= 1'b0;
        end
        else if (flt_if.valid && flt_if.ready)
        begin
            check_filtered(flt_if.roll_filtered, flt_if.pitch_filtered);
            if ($urandom_range(0, 49) == 0)
                snk_steady <= !snk_steady;
            w = draw_wait(snk_steady);
            snk_stall    <= w;
            flt_if.ready <= (w == 0);
        end
        else if (snk_stall != 0)
        begin
            snk_stall    <= snk_stall - 1;
            flt_if.ready <= (snk_stall == 1);
        end
        else
            flt_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (smp_if.valid && smp_if.ready) || (flt_if.valid && flt_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        attitude_t a;
        int count;
        int mode;
        int seg_len;
        int roll_lvl;
        int pitch_lvl;
        sample_t hold_roll;
        sample_t hold_pitch;

        error_count = 0;
        idle_cycles = 0;
        in_hist     = '{default: '0};
        sect1_hist  = '{default: '0};
        sect2_hist  = '{default: '0};

        // zero, full-scale steps (output and section saturation), alternation, small values
        pending_samples.push_back('{roll: 16'sd0, pitch: 16'sd0});
        repeat (6) pending_samples.push_back('{roll: 16'sd32767, pitch: -16'sd32768});
        repeat (6) pending_samples.push_back('{roll: -16'sd32768, pitch: 16'sd32767});
        repeat (3)
        begin
            pending_samples.push_back('{roll: 16'sd32767, pitch: -16'sd32768});
            pending_samples.push_back('{roll: -16'sd32768, pitch: 16'sd32767});
        end
        pending_samples.push_back('{roll: 16'sd1, pitch: -16'sd1});
        pending_samples.push_back('{roll: -16'sd1, pitch: 16'sd1});
        pending_samples.push_back('{roll: 16'sd0, pitch: 16'sd0});
        pending_samples.push_back('{roll: 16'sd0, pitch: 16'sd0});

        count     = 0;
        roll_lvl  = 0;
        pitch_lvl = 0;
        while (count < RANDOM_REQUESTS)
        begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(8, 64);
            if ($urandom_range(0, 3) == 0)
            begin
                hold_roll  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                hold_pitch = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            else
            begin
                hold_roll  = random_sample();
                hold_pitch = random_sample();
            end
            repeat (seg_len)
            begin
                case (mode)
                    0:
                    begin
                        a.roll  = random_sample();
                        a.pitch = random_sample();
                    end
                    1:
                    begin
                        roll_lvl  = clamp_level(roll_lvl + $signed($urandom_range(0, 1024)) - 512);
                        pitch_lvl = clamp_level(pitch_lvl + $signed($urandom_range(0, 1024)) - 512);
                        a.roll    = sample_t'(roll_lvl);
                        a.pitch   = sample_t'(pitch_lvl);
                    end
                    2:
                    begin
                        a.roll  = hold_roll;
                        a.pitch = hold_pitch;
                    end
                    default:
                    begin
                        a.roll  = (count % 2 == 0) ? hold_roll : ~hold_roll;
                        a.pitch = (count % 2 == 0) ? ~hold_pitch : hold_pitch;
                    end
                endcase
                pending_samples.push_back(a);
                count++;
            end
        end

        @(posedge rst_n);
        while (pending_samples.size() != 0 || smp_if.valid || expected_filtered.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bwlpf_pkg.sv
rtl/core/bwlpf_sample_if.sv
rtl/core/bwlpf_filtered_if.sv
rtl/core/bwlpf_ctrl.sv
rtl/core/bwlpf_dp.sv
rtl/core/butterworth_lowpass_4th_dual.sv
rtl/core/bwlpf_checker.sv
tb/tb_top.sv
